// ----- src/rma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_pkg
// Shared constants, types and helpers for the ring moving average block.
// ----------------------------------------------------------------------------
package rma_pkg;

  localparam int RING_SLOTS = 16;
  localparam int SAMPLE_W   = 12;
  localparam int COUNT_W    = 4;
  localparam int PTR_W      = $clog2(RING_SLOTS);
  // exact peak sum is (RING_SLOTS-1) full-scale samples
  localparam int SUM_W      = $clog2((RING_SLOTS - 1) * ((1 << SAMPLE_W) - 1) + 1);
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  localparam logic [PTR_W:0]       SLOTS_EXT = (PTR_W + 1)'(RING_SLOTS);
  localparam logic [PTR_W-1:0]     PTR_LAST  = PTR_W'(RING_SLOTS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(SUM_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIVIDE,
    S_FINISH
  } rma_state_t;

  typedef struct packed {
    logic load;      // capture incoming sample
    logic update;    // ring/sum update, divider setup
    logic div_step;  // one restoring division step
    logic out_load;  // move quotient into output register
  } rma_cmd_t;

  typedef struct packed {
    logic div_last;  // current division step is the final one
  } rma_status_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_LAST) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

endpackage

// ----- src/rma_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_if
// Valid/ready channels for samples in and averages out.
// ----------------------------------------------------------------------------
interface rma_sample_if import rma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rma_result_if import rma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average;
  logic [COUNT_W-1:0]  held_count;

  modport source (output valid, output average, output held_count, input ready);
  modport sink   (input valid, input average, input held_count, output ready);
endinterface

// ----- src/rma_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/rma_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_datapath
// Ring pointers, running sum, sample RAM, serial divider, output register.
// ----------------------------------------------------------------------------
module rma_datapath import rma_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  rma_cmd_t            cmd,
  output rma_status_t         status,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic [SAMPLE_W-1:0] out_average,
  output logic [COUNT_W-1:0]  out_held_count
);

  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [SUM_W-1:0]     sum;
  logic [SAMPLE_W-1:0]  sample_reg;
  logic [SAMPLE_W-1:0]  rd_data;

  logic [PTR_W-1:0]     div_divisor;
  logic [PTR_W-1:0]     div_rem;
  logic [SUM_W-1:0]     div_quo;
  logic [DIV_CNT_W-1:0] step_cnt;

  logic                 full;
  logic [SUM_W-1:0]     sum_drop, sum_next;
  logic [PTR_W-1:0]     wr_ptr_next, rd_ptr_next;
  logic [PTR_W:0]       held_wide;
  logic [PTR_W-1:0]     held_next;
  logic [PTR_W:0]       trial;
  logic                 trial_ok;

  // oldest sample always sits at rd_ptr; RAM read runs every cycle
  rma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_SLOTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (wr_ptr),
    .wr_data (sample_reg),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  always_comb begin
    full        = (ptr_next(wr_ptr) == rd_ptr);
    sum_drop    = full ? (sum - SUM_W'(rd_data)) : sum;
    sum_next    = sum_drop + SUM_W'(sample_reg);
    rd_ptr_next = full ? ptr_next(rd_ptr) : rd_ptr;
    wr_ptr_next = ptr_next(wr_ptr);
    if (wr_ptr_next >= rd_ptr_next) begin
      held_wide = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
    end else begin
      held_wide = {1'b0, wr_ptr_next} + SLOTS_EXT - {1'b0, rd_ptr_next};
    end
    held_next = held_wide[PTR_W-1:0];
  end

  // restoring division, one quotient bit per step
  always_comb begin
    trial    = {div_rem, div_quo[SUM_W-1]};
    trial_ok = (trial >= {1'b0, div_divisor});
  end

  assign status.div_last = (step_cnt == DIV_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      sum      <= '0;
      step_cnt <= '0;
    end else if (cmd.update) begin
      wr_ptr   <= wr_ptr_next;
      rd_ptr   <= rd_ptr_next;
      sum      <= sum_next;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_reg <= in_sample;
    end
    if (cmd.update) begin
      div_divisor <= held_next;
      div_rem     <= '0;
      div_quo     <= sum_next;
    end else if (cmd.div_step) begin
      div_rem <= trial_ok ? PTR_W'(trial - {1'b0, div_divisor}) : trial[PTR_W-1:0];
      div_quo <= {div_quo[SUM_W-2:0], trial_ok};
    end
    if (cmd.out_load) begin
      out_average    <= (div_divisor == '0) ? '0 : div_quo[SAMPLE_W-1:0];
      out_held_count <= COUNT_W'(div_divisor);
    end
  end

  // a sample is always held once the ring has been updated
  a_held_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> div_divisor != '0)
    else $error("held count zero after update");

  // ring occupancy never exceeds slot count minus one
  a_not_overfull: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> wr_ptr_next != rd_ptr_next)
    else $error("ring pointers collided");

endmodule

// ----- src/rma_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_ctrl
// Sequencer for accept, update, divide and output handoff.
// ----------------------------------------------------------------------------
module rma_ctrl import rma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output rma_cmd_t    cmd,
  input  rma_status_t status
);

  rma_state_t state, state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_UPDATE;
      S_UPDATE: state_next = S_DIVIDE;
      S_DIVIDE: if (status.div_last) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_UPDATE: cmd.update = 1'b1;
      S_DIVIDE: cmd.div_step = 1'b1;
      S_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_updates: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_UPDATE)
    else $error("accepted transaction not followed by update");

  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !out_ready) |=> state == S_FINISH)
    else $error("result overwritten while output stalled");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("output load did not raise valid");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.update, cmd.div_step, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule

// ----- src/ring_moving_average_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_moving_average_core
// Sliding-window mean of 12-bit ADC samples over a ring of sample slots.
// ----------------------------------------------------------------------------
// Usage:
//   samples : valid/ready sink, one 12-bit ADC sample per transaction.
//   results : valid/ready source, average (12 bits) and held_count (4 bits),
//             exactly one result transaction per sample transaction.
//   The window holds up to RING_SLOTS-1 samples; once full, the oldest is
//   dropped from the running sum before the new one is added.
// Timing:
//   Accept cycle, update cycle (RAM write, sum, pointers), restoring
//   division (one quotient bit per cycle), handoff cycle. A new sample
//   is taken only once the previous one has passed through division and
//   handoff into the output register.
//   The output register decouples the sides: a new sample is accepted
//   while the previous result still waits. If the receiver stalls, the
//   next result is held in the divider until the output register frees.
// Reset:
//   Synchronous, active high. Empties the window (pointers and sum to
//   zero) and drops any pending result. Sample RAM contents are not
//   cleared; slots are only read after they have been written.
// ----------------------------------------------------------------------------
module ring_moving_average_core import rma_pkg::*; (
  input logic          clk,
  input logic          rst,
  rma_sample_if.sink   samples,
  rma_result_if.source results
);

  rma_cmd_t    cmd;
  rma_status_t status;

  // sequencing: state machine drives the datapath by command struct
  rma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // storage, arithmetic and output register
  rma_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_sample      (samples.sample),
    .out_average    (results.average),
    .out_held_count (results.held_count)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ring_moving_average_core. A behavioral window
// (ring, pointers, exact sum) predicts the mean and held count of every
// accepted sample transaction. Each result transaction is compared with the
// oldest prediction. Directed extremes come first, then random noise,
// steady runs and an unthrottled stretch. Both channels throttle at random.
// ----------------------------------------------------------------------------
module tb;
  import rma_pkg::*;

  // The drain wait after the last result leaves room for a straggler.
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 8;
  localparam int MAX_GAP      = 24;
  // receiver stall bursts stay short
  localparam int STALL_MAX    = 2;

  logic clk;
  logic rst;

  rma_sample_if samples ();
  rma_result_if results ();

  ring_moving_average_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  // One predicted result transaction.
  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [COUNT_W-1:0]  held_count;
  } mean_t;

  mean_t pending_means[$];
  mean_t head_mean;
  int    fail_count = 0;
  bit    calm;            // set: neither side throttles
  int    stall_left = 0;  // cycles of ready low still to go

  // Behavioral copy of the window.
  logic [SAMPLE_W-1:0] window_mem [RING_SLOTS];
  int unsigned         win_wr;
  int unsigned         win_rd;
  int unsigned         win_sum;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned slot_after(input int unsigned p);
    return (p + 1 == RING_SLOTS) ? 0 : p + 1;
  endfunction

  // Advance the window by one sample and return the expected result.
  // When the ring is full (one slot spare) the oldest sample leaves first.
  function automatic mean_t window_update(input logic [SAMPLE_W-1:0] s);
    mean_t       m;
    int unsigned held;
    int unsigned quot;
    if (slot_after(win_wr) == win_rd) begin
      win_sum = win_sum - window_mem[win_rd];
      win_rd  = slot_after(win_rd);
    end
    window_mem[win_wr] = s;
    win_wr  = slot_after(win_wr);
    win_sum = win_sum + s;
    held = (win_wr + RING_SLOTS - win_rd) % RING_SLOTS;
    // empty window gives zero, no division
    quot = (held == 0) ? 0 : win_sum / held;
    m.average    = quot[SAMPLE_W-1:0];
    m.held_count = held[COUNT_W-1:0];
    return m;
  endfunction

  // Drive one sample transaction. Entered and left at a falling edge; valid
  // stays high on return so back-to-back transactions need no toggle.
  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(MAX_GAP, 1);
    end
    while (gap > 0) begin
      samples.valid <= 1'b0;
      @(negedge clk);
      gap--;
    end
    samples.valid  <= 1'b1;
    samples.sample <= s;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    // accepted at this edge: predict now, in acceptance order
    pending_means.push_back(window_update(s));
    @(negedge clk);
  endtask

  // Receiver throttling: ready drops in random bursts unless calm.
  always @(negedge clk) begin
    if (rst) begin
      stall_left    = 0;
      results.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      results.ready <= 1'b0;
    end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
      stall_left    = $urandom_range(STALL_MAX, 1) - 1;
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  // Result checker: every result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (pending_means.size() == 0) begin
        $error("unexpected result: average %0d held_count %0d",
               results.average, results.held_count);
        fail_count++;
      end else begin
        head_mean = pending_means.pop_front();
        if (results.average !== head_mean.average) begin
          $error("average: expected %0d, actual %0d", head_mean.average, results.average);
          fail_count++;
        end
        if (results.held_count !== head_mean.held_count) begin
          $error("held_count: expected %0d, actual %0d",
                 head_mean.held_count, results.held_count);
          fail_count++;
        end
      end
    end
  end

  // Full-scale fill up to and past the full window (peak sum, first drop),
  // then zeros, bit patterns and the extremes again.
  task automatic test_extremes();
    repeat (RING_SLOTS) push_sample({SAMPLE_W{1'b1}});
    repeat (3) push_sample('0);
    push_sample(SAMPLE_W'(1));
    push_sample({SAMPLE_W{1'b1}} - 1'b1);
    push_sample(SAMPLE_W'(12'h800));
    push_sample(SAMPLE_W'(12'hAAA));
    push_sample(SAMPLE_W'(12'h555));
    push_sample({SAMPLE_W{1'b1}});
  endtask

  // Uniform noise with a sprinkle of rail values.
  task automatic test_random_noise(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 5)       push_sample('0);
      else if (pick < 10) push_sample({SAMPLE_W{1'b1}});
      else                push_sample(SAMPLE_W'($urandom));
    end
  endtask

  // Constant runs around the window length; the longer ones let the mean settle
  // on each level as the old level drains out sample by sample.
  task automatic test_steady_runs(input int runs);
    logic [SAMPLE_W-1:0] level;
    int                  len;
    repeat (runs) begin
      case ($urandom_range(3))
        0:       level = '0;
        1:       level = {SAMPLE_W{1'b1}};
        default: level = SAMPLE_W'($urandom);
      endcase
      len = $urandom_range(RING_SLOTS + 6, RING_SLOTS - 4);
      repeat (len) push_sample(level);
    end
  endtask

  // Long stretch at full rate on both sides: walking ones, rail toggles and
  // noise back to back.
  task automatic test_full_rate(input int n);
    int i;
    calm = 1'b1;
    for (i = 0; i < n; i++) begin
      case (i % 3)
        0:       push_sample(SAMPLE_W'(1) << (i % SAMPLE_W));
        1:       push_sample((i % 2) ? {SAMPLE_W{1'b1}} : '0);
        default: push_sample(SAMPLE_W'($urandom));
      endcase
    end
    calm = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    calm           = 1'b0;
    samples.valid  = 1'b0;
    samples.sample = '0;
    win_wr         = 0;
    win_rd         = 0;
    win_sum        = 0;
    foreach (window_mem[i]) window_mem[i] = '0;

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_extremes();
    test_random_noise(150);
    test_steady_runs(7);
    test_full_rate(120);

    samples.valid <= 1'b0;
    wait (pending_means.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
